// ===== hw/rtl/midi_in_packet_queue_top_defines.svh =====
// Assertion macros used by the checker of the MIDI IN packet queue.
`ifndef MIDI_IN_PACKET_QUEUE_TOP_DEFINES_SVH
`define MIDI_IN_PACKET_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define MIPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define MIPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mipq_pkg.sv =====
// Package for the MIDI IN packet queue: sizes, codes, payload types and index helpers.
package mipq_pkg;

  localparam int QUEUE_PACKETS  = 256;
  localparam int MAX_IN_PACKETS = 16;

  localparam int IDX_W = $clog2(QUEUE_PACKETS);
  localparam int CNT_W = $clog2(MAX_IN_PACKETS + 1);
  localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   idx_ext_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CMP_W-1:0] cmp_t;

  // Request codes.
  localparam logic [1:0] REQ_SEND    = 2'd0;
  localparam logic [1:0] REQ_DONE    = 2'd1;
  localparam logic [1:0] REQ_SUSPEND = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_XFER   = 2'd2;
  localparam logic [1:0] KIND_IDLE   = 2'd3;

  // What an accepted item leads to.
  localparam logic [1:0] DEC_NONE      = 2'd0;
  localparam logic [1:0] DEC_ONE       = 2'd1;
  localparam logic [1:0] DEC_ACK_DRAIN = 2'd2;
  localparam logic [1:0] DEC_DRAIN     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] packet_data;
    logic [7:0]  message_packets;
    logic        first_of_message;
    logic        last_of_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] packet_out;
    logic [6:0]  transfer_bytes;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic chunk;
    logic read;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] dec;
    logic       more;
  } dp_stat_t;

  function automatic idx_t idx_adv(idx_t i);
    idx_t r;
    if (i == idx_t'(QUEUE_PACKETS - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t idx_dist(idx_t frm, idx_t dst);
    idx_ext_t t;
    if (dst >= frm) begin
      t = {1'b0, dst} - {1'b0, frm};
    end else begin
      t = idx_ext_t'(QUEUE_PACKETS) + {1'b0, dst} - {1'b0, frm};
    end
    return t[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/mipq_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module mipq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mipq_dp.sv =====
// Datapath of the MIDI IN packet queue: ring indexes, message admission, packet store, result register.
module mipq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mipq_pkg::in_item_t   in_item,
  input  mipq_pkg::ctl_cmd_t   cmd,
  output mipq_pkg::dp_stat_t   stat,
  output mipq_pkg::out_item_t  out_item
);
  import mipq_pkg::*;

  idx_t wr_idx_r, wr_idx_nxt;
  idx_t rd_idx_r, rd_idx_nxt;
  idx_t fill_idx_r, fill_idx_nxt;
  logic busy_r, busy_nxt;
  logic drop_r, drop_nxt;
  logic recv_r, recv_nxt;
  cnt_t remain_r, remain_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       last_r, last_nxt;
  logic [6:0] bytes_r, bytes_nxt;

  logic [1:0]  dec;
  logic        mem_we;
  idx_t        fill0;
  idx_t        fill1;
  idx_t        room;
  idx_t        avail;
  cnt_t        chunk_n;
  logic        reject;
  logic        recv1;
  logic [31:0] ram_rdata;

  always_comb begin
    fill0  = in_item.first_of_message ? wr_idx_r : fill_idx_r;
    room   = idx_t'(QUEUE_PACKETS - 1) - idx_dist(rd_idx_r, wr_idx_r);
    reject = in_item.first_of_message &&
             (cmp_t'(in_item.message_packets) > cmp_t'(room));
    recv1  = in_item.first_of_message | recv_r;
    avail  = idx_dist(rd_idx_r, wr_idx_r);
    if (cmp_t'(avail) > cmp_t'(MAX_IN_PACKETS)) begin
      chunk_n = cnt_t'(MAX_IN_PACKETS);
    end else begin
      chunk_n = cnt_t'(avail);
    end
  end

  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    fill_idx_nxt = fill_idx_r;
    busy_nxt     = busy_r;
    drop_nxt     = drop_r;
    recv_nxt     = recv_r;
    remain_nxt   = remain_r;
    kind_nxt     = kind_r;
    last_nxt     = last_r;
    bytes_nxt    = bytes_r;
    dec          = DEC_NONE;
    mem_we       = 1'b0;
    fill1        = fill0;

    if (cmd.accept) begin
      case (in_item.req_type)
        REQ_SEND: begin
          fill_idx_nxt = fill0;
          if (in_item.first_of_message) begin
            drop_nxt = 1'b0;
            recv_nxt = 1'b0;
          end
          if (reject) begin
            drop_nxt = !in_item.last_of_message;
            dec      = DEC_ONE;
            kind_nxt = KIND_REJECT;
          end else if (drop_r && !in_item.first_of_message) begin
            if (in_item.last_of_message) begin
              drop_nxt = 1'b0;
            end
          end else if (recv1) begin
            // A packet that finds the ring full is discarded.
            if (idx_adv(fill0) != rd_idx_r) begin
              mem_we = 1'b1;
              fill1  = idx_adv(fill0);
            end
            fill_idx_nxt = fill1;
            recv_nxt     = 1'b1;
            if (in_item.last_of_message) begin
              wr_idx_nxt = fill1;
              recv_nxt   = 1'b0;
              kind_nxt   = KIND_ACCEPT;
              if (!busy_r && fill1 != rd_idx_r) begin
                busy_nxt = 1'b1;
                dec      = DEC_ACK_DRAIN;
              end else begin
                dec = DEC_ONE;
              end
            end
          end
        end
        REQ_DONE: begin
          if (busy_r) begin
            if (wr_idx_r != rd_idx_r) begin
              dec = DEC_DRAIN;
            end else begin
              busy_nxt = 1'b0;
              kind_nxt = KIND_IDLE;
              dec      = DEC_ONE;
            end
          end
        end
        REQ_SUSPEND: begin
          wr_idx_nxt   = '0;
          rd_idx_nxt   = '0;
          fill_idx_nxt = '0;
          busy_nxt     = 1'b0;
          drop_nxt     = 1'b0;
          recv_nxt     = 1'b0;
        end
        default: begin
        end
      endcase
      last_nxt = (dec == DEC_ONE);
    end

    if (cmd.chunk) begin
      remain_nxt = chunk_n;
      bytes_nxt  = {chunk_n, 2'b00};
    end

    if (cmd.read) begin
      rd_idx_nxt = idx_adv(rd_idx_r);
      remain_nxt = remain_r - cnt_t'(1);
      kind_nxt   = KIND_XFER;
      last_nxt   = (remain_r == cnt_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      fill_idx_r <= '0;
      busy_r     <= 1'b0;
      drop_r     <= 1'b0;
      recv_r     <= 1'b0;
      remain_r   <= '0;
    end else begin
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      fill_idx_r <= fill_idx_nxt;
      busy_r     <= busy_nxt;
      drop_r     <= drop_nxt;
      recv_r     <= recv_nxt;
      remain_r   <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    last_r  <= last_nxt;
    bytes_r <= bytes_nxt;
  end

  mipq_ram #(
    .WIDTH(32),
    .DEPTH(QUEUE_PACKETS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill0),
    .wdata (in_item.packet_data),
    .re    (cmd.read),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign stat.dec  = dec;
  assign stat.more = (remain_r != '0);

  assign out_item.result_kind    = kind_r;
  assign out_item.packet_out     = (kind_r == KIND_XFER) ? ram_rdata : '0;
  assign out_item.transfer_bytes = (kind_r == KIND_XFER) ? bytes_r : '0;
  assign out_item.last_result    = last_r;

endmodule

// ===== hw/rtl/mipq_ctl.sv =====
// Controller of the MIDI IN packet queue: sequences item intake, chunk sizing, RAM reads and results.
module mipq_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output mipq_pkg::ctl_cmd_t cmd,
  input  mipq_pkg::dp_stat_t stat
);
  import mipq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACK   = 3'd1;
  localparam logic [2:0] S_CHUNK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (stat.dec)
            DEC_ONE:       state_nxt = S_OUT;
            DEC_ACK_DRAIN: state_nxt = S_ACK;
            DEC_DRAIN:     state_nxt = S_CHUNK;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACK: begin
        if (!out_stall) begin
          state_nxt = S_CHUNK;
        end
      end
      S_CHUNK: state_nxt = S_READ;
      S_READ:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = stat.more ? S_READ : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_ACK) || (state_r == S_OUT);
  assign cmd.accept = (state_r == S_IDLE) && in_valid;
  assign cmd.chunk  = (state_r == S_CHUNK);
  assign cmd.read   = (state_r == S_READ);

endmodule

// ===== hw/rtl/midi_in_packet_queue_top.sv =====
// Top level of the MIDI IN packet queue.
// Usage: the input channel (in_valid, in_stall, in_item) takes send packets, IN
// transfer-complete notices and suspend requests; the result channel (out_valid,
// out_stall, out_item) returns accepted, rejected, transfer packet and idle results.
// An item is taken only while in_stall is low, which is the case whenever no earlier
// item still has results to deliver.
// An item without a result leaves the block idle. An item with a single result is taken
// and its result is offered in the next cycle.
// A chunk of packets is first sized in the CHUNK state; each packet then takes a packet
// RAM read in the READ state and is presented from the registered read data in the OUT
// state. A message that also starts a transfer delivers its accepted result first.
// Packets leave in queue order; the last result of every item carries last_result.
// When the receiver stalls, the pending result and its packet hold unchanged.
// Reset (rst_n low, synchronous) empties the ring and returns the block to idle; the
// packet RAM itself is not cleared and needs no clearing pass.
module midi_in_packet_queue_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mipq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mipq_pkg::out_item_t out_item
);
  import mipq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mipq_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  mipq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// ===== hw/rtl/mipq_checker.sv =====
// Port-level checker for the MIDI IN packet queue, bound to the top level.
`include "midi_in_packet_queue_top_defines.svh"

module mipq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mipq_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input mipq_pkg::out_item_t out_item
);
  import mipq_pkg::*;

  `MIPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
  `MIPQ_ASSERT_SAME(a_xfer_bytes, out_valid && out_item.result_kind == KIND_XFER, out_item.transfer_bytes != 7'd0 && out_item.transfer_bytes[1:0] == 2'b00 && out_item.transfer_bytes <= 7'(4 * MAX_IN_PACKETS), "bad transfer length")
  `MIPQ_ASSERT_SAME(a_no_payload, out_valid && out_item.result_kind != KIND_XFER, out_item.packet_out == 32'd0 && out_item.transfer_bytes == 7'd0, "payload on non-packet result")
  `MIPQ_ASSERT_SAME(a_single_last, out_valid && (out_item.result_kind == KIND_REJECT || out_item.result_kind == KIND_IDLE), out_item.last_result, "single result not marked last")
  `MIPQ_ASSERT_NEXT(a_ready_after_last, out_valid && !out_stall && out_item.last_result, !in_stall, "input not taken after final result")

endmodule

bind midi_in_packet_queue_top mipq_checker u_mipq_checker (.*);
